>>> design/ipv4fhg_pkg.sv
// package for the ipv4 fragment header generator
// operation codes, header word positions, reset values and the checksum add
// no dependencies
package ipv4fhg_pkg;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_NEXT  = 2'd2
    } op_t;

    localparam int          MAX_HEADER_WORDS_DEFAULT = 30;
    localparam int          WORD_INDEX_W             = 5;
    localparam int          IN_DATA_W                = 48;
    localparam int          OUT_DATA_W               = 80;

    localparam logic [15:0] PATH_MTU_RESET           = 16'd1500;
    localparam logic [5:0]  HEADER_BYTES_RESET       = 6'd20;

    localparam logic [4:0]  WORD_VERSION_IHL         = 5'd0;
    localparam logic [4:0]  WORD_TOTAL_LENGTH        = 5'd1;
    localparam logic [4:0]  WORD_FLAGS_OFFSET        = 5'd3;
    localparam logic [4:0]  WORD_CHECKSUM            = 5'd5;

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'b0, s[16]};
    endfunction

endpackage

>>> design/ipv4_fragment_header_gen.sv
// ipv4 fragment header generator, top level
// input register, single-pass fragment logic and a result register
// depends on ipv4fhg_pkg

// Takes one transfer per cycle on the slave side unless a next-fragment
// request waits on a held result. Header word loads and datagram starts give
// no result; each next-fragment request gives exactly one result transfer via
// the input register and then the result register. The sustained rate is one
// item per clock without back-pressure, set by the combinational path from
// the input register through the size compare and the two checksum folds
// into the result register. path_mtu_wr_en/path_mtu_wr_data write path_mtu;
// the user must write it only while the block is idle; it is not enforced.
module ipv4_fragment_header_gen #(
    parameter int MAX_HEADER_WORDS = ipv4fhg_pkg::MAX_HEADER_WORDS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              path_mtu_wr_en,
    input  logic [15:0]                       path_mtu_wr_data,

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // word_index[4:0], word_value[20:5], datagram_length[36:21],
    // header_bytes[42:37], zero fill [47:43]
    input  logic [ipv4fhg_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]                        s_axis_tuser,

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // offset_bytes[15:0], payload_bytes[31:16], flags_offset_word[45:32],
    // fragment_length[61:46], header_checksum[77:62], more_fragments[78],
    // zero fill [79]
    output logic [ipv4fhg_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // prepared[0]
    output logic                              m_axis_tuser
);

    localparam int WORD_INDEX_W = ipv4fhg_pkg::WORD_INDEX_W;

    // configuration and datagram state
    logic [15:0] path_mtu_reg;
    logic [15:0] fixed_word_sum_reg,   fixed_word_sum_next;
    logic [15:0] bytes_remaining_reg,  bytes_remaining_next;
    logic [15:0] payload_position_reg, payload_position_next;
    logic [5:0]  header_length_reg,    header_length_next;

    // input register
    logic                     in_valid_reg;
    ipv4fhg_pkg::op_t         in_op_reg;
    logic [WORD_INDEX_W-1:0]  in_index_reg;
    logic [15:0]              in_word_reg;
    logic [15:0]              in_dlen_reg;
    logic [5:0]               in_hlen_reg;

    // result register
    logic                                     out_valid_reg;
    logic [ipv4fhg_pkg::OUT_DATA_W-1:0]       out_data_reg, out_data_next;
    logic                                     out_prepared_reg, out_prepared_next;

    logic        in_take;
    logic        out_free;
    logic        in_advance;
    logic        out_load;

    logic [15:0] hlen_ext;
    logic [15:0] limit_raw;
    logic [15:0] limit;
    logic        more;
    logic [15:0] size;
    logic [15:0] flen;
    logic [13:0] fow;
    logic [15:0] sum_len;
    logic [15:0] sum_all;
    logic        has_fragment;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign in_advance    = in_valid_reg && (out_free || in_op_reg != ipv4fhg_pkg::OP_NEXT);
    assign out_load      = in_valid_reg && out_free && in_op_reg == ipv4fhg_pkg::OP_NEXT;
    assign s_axis_tready = !in_valid_reg || in_advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_prepared_reg;

    // fragment arithmetic
    always_comb
    begin
        hlen_ext     = {10'b0, header_length_reg};
        limit_raw    = (path_mtu_reg > hlen_ext) ? (path_mtu_reg - hlen_ext) : 16'd0;
        limit        = {limit_raw[15:3], 3'b000};
        more         = bytes_remaining_reg > limit;
        size         = more ? limit : bytes_remaining_reg;
        flen         = size + hlen_ext;
        fow          = {more, payload_position_reg[15:3]};
        sum_len      = ipv4fhg_pkg::ones_add(fixed_word_sum_reg, flen);
        sum_all      = ipv4fhg_pkg::ones_add(sum_len, {2'b00, fow});
        has_fragment = bytes_remaining_reg != 16'd0;
    end

    // state update and result formation
    always_comb
    begin
        fixed_word_sum_next   = fixed_word_sum_reg;
        bytes_remaining_next  = bytes_remaining_reg;
        payload_position_next = payload_position_reg;
        header_length_next    = header_length_reg;
        out_data_next         = '0;
        out_prepared_next     = 1'b0;

        if (in_advance)
        begin
            unique case (in_op_reg)
                ipv4fhg_pkg::OP_LOAD:
                begin
                    if (in_index_reg < WORD_INDEX_W'(MAX_HEADER_WORDS))
                    begin
                        if (in_index_reg == ipv4fhg_pkg::WORD_VERSION_IHL)
                        begin
                            fixed_word_sum_next = in_word_reg;
                        end
                        else if (in_index_reg != ipv4fhg_pkg::WORD_TOTAL_LENGTH &&
                                 in_index_reg != ipv4fhg_pkg::WORD_FLAGS_OFFSET &&
                                 in_index_reg != ipv4fhg_pkg::WORD_CHECKSUM)
                        begin
                            fixed_word_sum_next =
                                ipv4fhg_pkg::ones_add(fixed_word_sum_reg, in_word_reg);
                        end
                    end
                end
                ipv4fhg_pkg::OP_START:
                begin
                    header_length_next    = in_hlen_reg;
                    bytes_remaining_next  = (in_dlen_reg > {10'b0, in_hlen_reg}) ?
                                            (in_dlen_reg - {10'b0, in_hlen_reg}) : 16'd0;
                    payload_position_next = 16'd0;
                end
                ipv4fhg_pkg::OP_NEXT:
                begin
                    if (has_fragment)
                    begin
                        out_prepared_next     = 1'b1;
                        out_data_next         = {1'b0, more, ~sum_all, flen, fow,
                                                 size, payload_position_reg};
                        payload_position_next = payload_position_reg + size;
                        bytes_remaining_next  = bytes_remaining_reg - size;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            path_mtu_reg         <= ipv4fhg_pkg::PATH_MTU_RESET;
            fixed_word_sum_reg   <= 16'd0;
            bytes_remaining_reg  <= 16'd0;
            payload_position_reg <= 16'd0;
            header_length_reg    <= ipv4fhg_pkg::HEADER_BYTES_RESET;
            in_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (path_mtu_wr_en)
            begin
                path_mtu_reg <= path_mtu_wr_data;
            end
            fixed_word_sum_reg   <= fixed_word_sum_next;
            bytes_remaining_reg  <= bytes_remaining_next;
            payload_position_reg <= payload_position_next;
            header_length_reg    <= header_length_next;

            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (in_advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_op_reg    <= ipv4fhg_pkg::op_t'(s_axis_tuser);
            in_index_reg <= s_axis_tdata[4:0];
            in_word_reg  <= s_axis_tdata[20:5];
            in_dlen_reg  <= s_axis_tdata[36:21];
            in_hlen_reg  <= s_axis_tdata[42:37];
        end
        if (out_load)
        begin
            out_data_reg     <= out_data_next;
            out_prepared_reg <= out_prepared_next;
        end
    end

    // no-fragment results carry all-zero data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("no-fragment result with nonzero data");

    // a fragment with more following carries a multiple of eight bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[78] |-> m_axis_tdata[18:16] == 3'b000)
        else $error("non-final fragment payload not a multiple of eight");

    // the last fragment drains the datagram
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load && out_prepared_next && !out_data_next[78] |=> bytes_remaining_reg == 16'd0)
        else $error("bytes left after last fragment");

    // back-pressure only while an item is held
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && out_valid_reg && !m_axis_tready)
        else $error("input stalled without a blocked result");

endmodule
